/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the coalescer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* hw/rtl/hrrc_pkg.sv */
// Package: types and constants of the holding register read coalescer
`timescale 1ns / 1ps
`default_nettype none
package hrrc_pkg;

   localparam int PDU_SIZE_MAX  = 253;
   localparam int BYTES_PER_REG = 4;
   // registers per frame: ceil(PDU_SIZE_MAX / BYTES_PER_REG)
   localparam int FRAME_REGS    = (PDU_SIZE_MAX + BYTES_PER_REG - 1) / BYTES_PER_REG;

   localparam int ADDR_W  = 16;
   localparam int VALUE_W = 16;
   localparam int SLAVE_W = 8;
   localparam int COUNT_W = 7;
   localparam int MODE_W  = 2;

   localparam logic [SLAVE_W-1:0] SLAVE_RESET = 8'd1;

   localparam logic [MODE_W-1:0] MODE_READ_ONLY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_ONLY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ_WRITE = 2'd2;

   localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(FRAME_REGS);

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SLAVE_W-1:0] target_slave;
      logic [ADDR_W-1:0]  start_address;
      logic [COUNT_W-1:0] register_count;
      logic               run_last;
   } hrrc_req_type;

   // up to two read requests caused by one entry
   typedef struct packed {
      logic         push0;
      logic         push1;
      hrrc_req_type req0;
      hrrc_req_type req1;
   } hrrc_push_type;

endpackage
`default_nettype wire

/* hw/rtl/holding_register_read_coalescer.sv */
// Top level of the holding register read coalescer
`timescale 1ns / 1ps
`default_nettype none
// Accepts one register dictionary entry per cycle and merges runs of contiguous
// readable addresses into read requests (slave, start, count). An entry passes
// through one input register and a single compare-and-update step on the run
// state, so a new entry can enter every cycle; its zero, one or two requests
// land in a four-entry result queue and leave one per cycle unless stalled.
// Input stalls only while the queue holds more than two requests, i.e. when
// the result side is stalled or entries keep producing two requests each.
// target_slave is the slave address in effect when the entry is processed.
module holding_register_read_coalescer
   import hrrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [SLAVE_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [ADDR_W-1:0]  req_reg_address,
   input  wire logic [MODE_W-1:0]  req_access_mode,
   input  wire logic [VALUE_W-1:0] req_previous_value,
   input  wire logic [VALUE_W-1:0] req_current_value,
   input  wire logic               req_last_entry,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [SLAVE_W-1:0]      rsp_target_slave,
   output logic [ADDR_W-1:0]       rsp_start_address,
   output logic [COUNT_W-1:0]      rsp_register_count,
   output logic                    rsp_run_last
);

   logic [SLAVE_W-1:0] slave_address_ff;
   logic               room;
   hrrc_push_type      push;
   hrrc_req_type       head;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_RESET;
      end else if (csr_wr_en) begin
         slave_address_ff <= csr_wr_data;
      end
   end

   hrrc_core u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reg_address    (req_reg_address),
      .req_access_mode    (req_access_mode),
      .req_previous_value (req_previous_value),
      .req_current_value  (req_current_value),
      .req_last_entry     (req_last_entry),
      .slave_address      (slave_address_ff),
      .room               (room),
      .push               (push)
   );

   hrrc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_target_slave   = head.target_slave;
   assign rsp_start_address  = head.start_address;
   assign rsp_register_count = head.register_count;
   assign rsp_run_last       = head.run_last;

endmodule
`default_nettype wire

/* hw/rtl/hrrc_core.sv */
// Input register, run tracking state and request generation
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hrrc_core
   import hrrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [ADDR_W-1:0]  req_reg_address,
   input  wire logic [MODE_W-1:0]  req_access_mode,
   input  wire logic [VALUE_W-1:0] req_previous_value,
   input  wire logic [VALUE_W-1:0] req_current_value,
   input  wire logic               req_last_entry,
   input  wire logic [SLAVE_W-1:0] slave_address,
   input  wire logic               room,
   output hrrc_push_type           push
);

   logic               valid_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [VALUE_W-1:0] prev_ff;
   logic [VALUE_W-1:0] cur_ff;
   logic               last_ff;

   logic [ADDR_W-1:0]  last_address_ff, last_address_in;
   logic [ADDR_W-1:0]  run_start_ff, run_start_in;
   logic [COUNT_W-1:0] run_count_ff, run_count_in;

   logic          advance;
   logic          load;
   hrrc_push_type gen;

   assign advance   = valid_ff && room;
   assign load      = !valid_ff || room;
   assign req_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= req_reg_address;
         mode_ff <= req_access_mode;
         prev_ff <= req_previous_value;
         cur_ff  <= req_current_value;
         last_ff <= req_last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_address_ff <= '0;
         run_start_ff    <= '0;
         run_count_ff    <= '0;
      end else if (advance) begin
         last_address_ff <= last_address_in;
         run_start_ff    <= run_start_in;
         run_count_ff    <= run_count_in;
      end
   end

   // one pass over the entry: close runs, emit up to two requests
   always_comb begin
      logic               wo;
      logic               rw;
      logic               contig;
      logic [COUNT_W-1:0] c;
      logic [ADDR_W-1:0]  s;
      logic               n;
      wo     = (mode_ff == MODE_WRITE_ONLY);
      rw     = (mode_ff == MODE_READ_WRITE);
      contig = ({1'b0, addr_ff} == ({1'b0, last_address_ff} + 17'd1));
      c      = run_count_ff;
      s      = run_start_ff;
      n      = 1'b0;
      gen    = '0;
      gen.req0.target_slave = slave_address;
      gen.req1.target_slave = slave_address;

      if (!contig) begin
         if (c != '0) begin
            gen.push0               = 1'b1;
            gen.req0.start_address  = s;
            gen.req0.register_count = c;
            n                       = 1'b1;
            c                       = '0;
         end
         if (!wo) begin
            c = COUNT_W'(1);
            s = addr_ff;
         end
      end else begin
         if (c == '0 && !wo) begin
            s = addr_ff;
         end
         if (!wo) begin
            c = c + COUNT_W'(1);
         end
      end

      // changed read-write entry: drop it from the run
      if (rw && prev_ff != cur_ff) begin
         if (c > COUNT_W'(1)) begin
            if (n) begin
               gen.push1               = 1'b1;
               gen.req1.start_address  = s;
               gen.req1.register_count = c - COUNT_W'(1);
            end else begin
               gen.push0               = 1'b1;
               gen.req0.start_address  = s;
               gen.req0.register_count = c - COUNT_W'(1);
            end
            n = 1'b1;
         end
         c = '0;
      end

      if ((wo || last_ff) && c != '0) begin
         if (n) begin
            gen.push1               = 1'b1;
            gen.req1.start_address  = s;
            gen.req1.register_count = c;
         end else begin
            gen.push0               = 1'b1;
            gen.req0.start_address  = s;
            gen.req0.register_count = c;
         end
         n = 1'b1;
         c = '0;
      end

      // frame full: send and restart the run at this entry
      if (c >= FRAME_LIMIT) begin
         if (n) begin
            gen.push1               = 1'b1;
            gen.req1.start_address  = s;
            gen.req1.register_count = c;
         end else begin
            gen.push0               = 1'b1;
            gen.req0.start_address  = s;
            gen.req0.register_count = c;
         end
         c = COUNT_W'(1);
         s = addr_ff;
      end

      gen.req0.run_last = gen.push0 && !gen.push1;
      gen.req1.run_last = gen.push1;

      last_address_in = addr_ff;
      run_start_in    = s;
      run_count_in    = c;
      if (last_ff) begin
         last_address_in = '0;
         run_start_in    = '0;
         run_count_in    = '0;
      end
   end

   always_comb begin
      push       = gen;
      push.push0 = gen.push0 && advance;
      push.push1 = gen.push1 && advance;
   end

   `ASSERT_IMPLIES(a_push_order, clock, reset, push.push1, push.push0)
   `ASSERT_ALWAYS(a_run_below_frame, clock, reset, run_count_ff < FRAME_LIMIT)
   `ASSERT_NEXT(a_scan_end_clears, clock, reset, advance && last_ff,
      run_count_ff == '0 && last_address_ff == '0)

endmodule
`default_nettype wire

/* hw/rtl/hrrc_outq.sv */
// Result queue: takes up to two requests a cycle, releases one a cycle unless rsp_stall is high
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hrrc_outq
   import hrrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire hrrc_push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output hrrc_req_type       head
);

   hrrc_req_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [QCNT_W-1:0] n_push;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = entry_ff[rd_ptr_ff];
   // keep space for two requests of the next entry
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign n_push    = QCNT_W'(push.push0) + QCNT_W'(push.push1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + n_push - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push.req0;
      end
      if (push.push1) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.req1;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_push_needs_room, clock, reset, push.push0,
      count_ff <= QCNT_W'(QUEUE_DEPTH - 2))
   `ASSERT_ALWAYS(a_ptr_track, clock, reset,
      (wr_ptr_ff - rd_ptr_ff) == QPTR_W'(count_ff))

endmodule
`default_nettype wire
